/* hdl/crcwf_pkg.sv */
package crcwf_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CRC_W  = 32;
    localparam int unsigned CNT_W  = 4;
    localparam int unsigned MAX_ADVANCE_BITS = 64;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;

    // Advances a reflected CRC state over a number of zero bytes. It is only
    // called with constant arguments, so it folds away at elaboration.
    function automatic logic [CRC_W-1:0] zero_advance(input logic [CRC_W-1:0] state,
                                                      input int unsigned nbytes);
        logic [CRC_W-1:0] s;
        s = state;
        for (int unsigned i = 0; i < MAX_ADVANCE_BITS; i++) begin
            if (i < nbytes * BYTE_W) begin
                s = s[0] ? ((s >> 1) ^ CRC_POLY) : (s >> 1);
            end
        end
        return s;
    endfunction

endpackage

/* hdl/crcwf_lane.sv */
module crcwf_lane #(
    parameter int unsigned ADVANCE_BYTES = 1
) (
    input  logic [crcwf_pkg::BYTE_W-1:0] byte_in,
    output logic [crcwf_pkg::CRC_W-1:0]  crc_part
);

    logic [crcwf_pkg::BYTE_W-1:0][crcwf_pkg::CRC_W-1:0] term;

    // Each input bit maps to a fixed 32-bit column: the zero-state CRC of that
    // bit pushed through its own byte and the bytes that follow it in the word.
    for (genvar j = 0; j < crcwf_pkg::BYTE_W; j++) begin : g_col
        localparam logic [crcwf_pkg::CRC_W-1:0] COL =
            crcwf_pkg::zero_advance(crcwf_pkg::CRC_W'(1) << j, ADVANCE_BYTES);
        assign term[j] = {crcwf_pkg::CRC_W{byte_in[j]}} & COL;
    end

    always_comb begin
        crc_part = '0;
        for (int j = 0; j < crcwf_pkg::BYTE_W; j++) begin
            crc_part = crc_part ^ term[j];
        end
    end

endmodule

/* hdl/crcwf_merge.sv */
module crcwf_merge #(
    parameter int unsigned LANES = 8
) (
    input  logic [LANES-1:0][crcwf_pkg::CRC_W-1:0] lane_crc,
    input  logic [crcwf_pkg::CRC_W-1:0]            remnant,
    output logic [crcwf_pkg::CRC_W-1:0]            crc_out
);

    // The CRC is linear, so the lanes and the unconsumed seed bits simply add.
    always_comb begin
        crc_out = remnant;
        for (int k = 0; k < LANES; k++) begin
            crc_out = crc_out ^ lane_crc[k];
        end
    end

endmodule

/* hdl/crc32_word_fold_core.sv */
// Reflected CRC-32 (polynomial 0xEDB88320, no inversions) over messages sent
// as little-endian words of BYTES_PER_WORD bytes.
// Input stream: s_tdata carries the word and its valid byte count, s_tlast
// marks the final word of a message. Counts above BYTES_PER_WORD saturate;
// a count of zero folds nothing.
// Output stream: one request per message, issued for the word marked last,
// with m_tdata holding the final CRC state.
// The start value is written through cfg_we/cfg_wdata and is loaded into
// the running state at the first word of each message.
// Throughput is one word per cycle while s_tready is high: every byte lane
// and the merge XOR tree work in the same cycle on the running state register.
// m_tvalid rises in the cycle after the last word's acceptance.
// The output register decouples the sides: a new word is taken while a
// result is waiting, and s_tready drops only when a result is held and
// the receiver stalls.
// Reset clears the start value to zero, ends any open message and empties
// the output register.
module crc32_word_fold_core #(
    parameter int unsigned BYTES_PER_WORD = 8
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // Fields from bit 0: data_word [8*BYTES_PER_WORD], byte_count [4], zero pad.
    input  logic [8*BYTES_PER_WORD+7:0]             s_tdata,
    input  logic                                    s_tlast,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // Fields from bit 0: crc [32].
    output logic [crcwf_pkg::CRC_W-1:0]             m_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    input  logic                                    cfg_we,
    input  logic [crcwf_pkg::CRC_W-1:0]             cfg_wdata
);

    localparam int unsigned DATA_W = crcwf_pkg::BYTE_W * BYTES_PER_WORD;
    localparam int unsigned SEXT_W = DATA_W + crcwf_pkg::CRC_W;
    localparam logic [crcwf_pkg::CNT_W-1:0] BPW_N = crcwf_pkg::CNT_W'(BYTES_PER_WORD);

    logic [crcwf_pkg::CRC_W-1:0] start_value_reg;
    logic [crcwf_pkg::CRC_W-1:0] crc_reg;
    logic                        in_message_reg;
    logic [crcwf_pkg::CRC_W-1:0] m_data_reg;
    logic                        m_valid_reg;

    logic                        s_acc;
    logic [DATA_W-1:0]           data_word;
    logic [crcwf_pkg::CNT_W-1:0] byte_count;
    logic [crcwf_pkg::CNT_W-1:0] cnt;
    logic [crcwf_pkg::CNT_W-1:0] pad_bytes;
    logic [crcwf_pkg::CRC_W-1:0] seed;
    logic [SEXT_W-1:0]           seed_ext;
    logic [DATA_W-1:0]           t_word;
    logic [DATA_W-1:0]           aligned;
    logic [crcwf_pkg::CRC_W-1:0] remnant;
    logic [crcwf_pkg::CRC_W-1:0] crc_next;
    logic [BYTES_PER_WORD-1:0][crcwf_pkg::CRC_W-1:0] lane_crc;

    assign data_word  = s_tdata[DATA_W-1:0];
    assign byte_count = s_tdata[DATA_W+crcwf_pkg::CNT_W-1:DATA_W];

    assign s_tready = !m_valid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;
    assign m_tdata  = m_data_reg;
    assign m_tvalid = m_valid_reg;

    assign cnt       = (byte_count > BPW_N) ? BPW_N : byte_count;
    assign pad_bytes = BPW_N - cnt;
    assign seed      = in_message_reg ? crc_reg : start_value_reg;
    assign seed_ext  = SEXT_W'(seed);

    // The seed is folded into the first message bytes; valid bytes are then
    // moved to the top of the word so that leading zero bytes, which do not
    // change a zero-state CRC, take the place of the missing ones.
    always_comb begin
        t_word = '0;
        for (int k = 0; k < BYTES_PER_WORD; k++) begin
            if (crcwf_pkg::CNT_W'(k) < cnt) begin
                t_word[crcwf_pkg::BYTE_W*k +: crcwf_pkg::BYTE_W] =
                    data_word[crcwf_pkg::BYTE_W*k +: crcwf_pkg::BYTE_W] ^
                    seed_ext[crcwf_pkg::BYTE_W*k +: crcwf_pkg::BYTE_W];
            end
        end
    end

    assign aligned = t_word << {pad_bytes, 3'b000};
    // Seed bits beyond the consumed bytes shift down untouched.
    assign remnant = seed >> {cnt, 3'b000};

    for (genvar p = 0; p < BYTES_PER_WORD; p++) begin : g_lane
        crcwf_lane #(
            .ADVANCE_BYTES(BYTES_PER_WORD - p)
        ) u_lane (
            .byte_in (aligned[crcwf_pkg::BYTE_W*p +: crcwf_pkg::BYTE_W]),
            .crc_part(lane_crc[p])
        );
    end

    crcwf_merge #(
        .LANES(BYTES_PER_WORD)
    ) u_merge (
        .lane_crc(lane_crc),
        .remnant (remnant),
        .crc_out (crc_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_value_reg <= '0;
            crc_reg         <= '0;
            in_message_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                start_value_reg <= cfg_wdata;
            end
            if (s_acc) begin
                crc_reg        <= crc_next;
                in_message_reg <= !s_tlast;
            end
            if (s_acc && s_tlast) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc && s_tlast) begin
            m_data_reg <= crc_next;
        end
    end

    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_tlast |=> m_tvalid && m_tdata == crc_reg)
        else $error("last word did not produce its result");

    a_last_closes_message: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> in_message_reg == !$past(s_tlast))
        else $error("message state does not follow the last flag");

    a_empty_word_keeps_seed: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && byte_count == '0 |=> crc_reg == $past(seed))
        else $error("word without bytes changed the CRC state");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while a result is stalled");

endmodule

/* sim/crc32_word_fold_core_tb.sv */
`timescale 1ns / 100ps

module crc32_word_fold_core_tb;

    localparam int WORD_BYTES  = 8;
    localparam int CYCLE_LIMIT = 250000;

    logic                        aclk;
    logic                        aresetn;
    // Fields from bit 0: data_word [64], byte_count [4], zero pad [4].
    logic [8*WORD_BYTES+7:0]     s_tdata;
    logic                        s_tlast;
    logic                        s_tvalid;
    logic                        s_tready;
    // Fields from bit 0: crc [32].
    logic [crcwf_pkg::CRC_W-1:0] m_tdata;
    logic                        m_tvalid;
    logic                        m_tready;
    logic                        cfg_we;
    logic [crcwf_pkg::CRC_W-1:0] cfg_wdata;

    // Predictor state.
    logic [31:0] crc_seed;
    logic [31:0] crc_running;
    logic        msg_open;
    logic [31:0] crc_expected[$];

    int mismatches;
    int cycle_count;
    int long_hold;
    bit src_idle;
    bit sink_idle;

    crc32_word_fold_core #(
        .BYTES_PER_WORD(WORD_BYTES)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Byte-serial reflected CRC-32 over the low n bytes of a word.
    function automatic logic [31:0] crc_fold_word(input logic [31:0] state,
                                                  input logic [63:0] word,
                                                  input int n);
        logic [31:0] s;
        s = state;
        for (int k = 0; k < n; k++) begin
            s = s ^ {24'h0, word[8*k +: 8]};
            for (int b = 0; b < 8; b++) begin
                s = s[0] ? ((s >> 1) ^ 32'hEDB8_8320) : (s >> 1);
            end
        end
        return s;
    endfunction

    function automatic int draw_gap(input bit enabled);
        if (!enabled || $urandom_range(0, 1) == 0) begin
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    // Drives one word and returns at the edge where it is taken. The valid
    // stays high so that a following word can go out in the next cycle.
    task automatic send_word(input logic [63:0] word, input logic [3:0] count,
                             input logic is_last);
        int gap;
        int n;
        gap = draw_gap(src_idle);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {4'h0, count, word};
        s_tlast  <= is_last;
        s_tvalid <= 1'b1;

        n = (count > WORD_BYTES) ? WORD_BYTES : count;
        if (!msg_open) begin
            crc_running = crc_seed;
            msg_open    = 1'b1;
        end
        crc_running = crc_fold_word(crc_running, word, n);
        if (is_last) begin
            crc_expected.push_back(crc_running);
            msg_open = 1'b0;
        end

        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Lowers the request after the last word of a burst and lets the block settle.
    task automatic wait_quiet;
        s_tvalid <= 1'b0;
        while (crc_expected.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_start_value(input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        crc_seed = value;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_random_message(output int nwords);
        logic [3:0] count;
        nwords = $urandom_range(1, 6);
        for (int i = 0; i < nwords; i++) begin
            if (i != nwords - 1) begin
                count = ($urandom_range(0, 9) < 8) ? 4'd8 : 4'($urandom_range(0, 7));
            end else if ($urandom_range(0, 19) < 16) begin
                count = 4'($urandom_range(1, 8));
            end else begin
                count = 4'($urandom_range(0, 15));
            end
            send_word({$urandom, $urandom}, count, i == nwords - 1);
        end
    endtask

    task automatic test_reset_seed;
        send_word(64'h0123_4567_89AB_CDEF, 4'd8, 1'b1);
        send_word(64'h0, 4'd0, 1'b1);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 1'b1);
        wait_quiet();
    endtask

    task automatic test_directed;
        write_start_value(32'hFFFF_FFFF);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1);
        send_word(64'h0, 4'd8, 1'b1);
        send_word(64'hDEAD_BEEF_CAFE_0031, 4'd1, 1'b1);
        send_word(64'hDEAD_BEEF_CAFE_3231, 4'd2, 1'b1);
        send_word(64'hFFFF_FFFF_FF33_3231, 4'd3, 1'b1);
        // An empty message returns the start value unchanged.
        send_word(64'hA5A5_A5A5_A5A5_A5A5, 4'd0, 1'b1);
        // Counts above the word size fold all eight bytes.
        send_word(64'h8877_6655_4433_2211, 4'd9, 1'b1);
        send_word(64'h1122_3344_5566_7788, 4'd15, 1'b1);
        // Multi-word messages with partial and empty words in the middle.
        send_word(64'h0706_0504_0302_0100, 4'd8, 1'b0);
        send_word(64'hF0F0_F0F0_F00E_0D0C, 4'd3, 1'b0);
        send_word(64'h5555_5555_5555_5555, 4'd0, 1'b0);
        send_word(64'hAAAA_AAAA_AA15_1413, 4'd5, 1'b1);
        send_word(64'h8000_0000_0000_0000, 4'd8, 1'b0);
        send_word(64'h0000_0000_0000_0001, 4'd7, 1'b1);
        wait_quiet();
        write_start_value(32'h0000_0000);
        send_word(64'h7FFF_FFFF_FFFF_FFFE, 4'd4, 1'b1);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1);
        wait_quiet();
    endtask

    // A start value written inside an open message only applies to the next one.
    task automatic test_mid_message_config;
        write_start_value(32'h1234_5678);
        send_word(64'h0F1E_2D3C_4B5A_6978, 4'd8, 1'b0);
        wait_quiet();
        write_start_value(32'hCAFE_F00D);
        send_word(64'h0000_0000_9988_7766, 4'd4, 1'b1);
        send_word(64'h0000_0000_9988_7766, 4'd4, 1'b1);
        wait_quiet();
    endtask

    task automatic test_backpressure;
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        long_hold = 80;
        for (int i = 0; i < 30; i++) begin
            send_word({$urandom, $urandom}, 4'($urandom_range(1, 8)), 1'b1);
        end
        wait_quiet();
    endtask

    task automatic test_random;
        int sent;
        int nw;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    write_start_value(32'hFFFF_FFFF);
                    src_idle  = 1'b0;
                    sink_idle = 1'b0;
                end
                1: begin
                    write_start_value(32'h0000_0000);
                    src_idle  = 1'b1;
                    sink_idle = 1'b1;
                end
                default: begin
                    write_start_value($urandom);
                    src_idle  = 1'($urandom_range(0, 1));
                    sink_idle = 1'($urandom_range(0, 1));
                end
            endcase
            sent = 0;
            while (sent < 85) begin
                send_random_message(nw);
                sent = sent + nw;
            end
            wait_quiet();
        end
    endtask

    // Result sink with its own stall pattern and the long hold-off.
    initial begin
        int stall;
        m_tready <= 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (long_hold > 0) begin
                m_tready <= 1'b0;
                repeat (long_hold) @(posedge aclk);
                long_hold = 0;
            end else begin
                stall = draw_gap(sink_idle);
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
                m_tready <= 1'b1;
                do @(posedge aclk); while (!m_tvalid && long_hold == 0);
            end
        end
    end

    always @(posedge aclk) begin
        logic [31:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (crc_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: crc %08h", m_tdata);
                end
            end else begin
                want = crc_expected.pop_front();
                if (m_tdata !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("crc mismatch: expected %08h, got %08h", want, m_tdata);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("crc32_word_fold_core_tb: errors");
            $finish;
        end
    end

    initial begin
        mismatches  = 0;
        cycle_count = 0;
        long_hold   = 0;
        src_idle    = 1'b1;
        sink_idle   = 1'b1;
        crc_seed    = 32'h0;
        crc_running = 32'h0;
        msg_open    = 1'b0;
        aresetn   <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        s_tvalid  <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_seed();
        test_directed();
        test_mid_message_config();
        test_backpressure();
        test_random();

        if (mismatches == 0 && crc_expected.size() == 0) begin
            $display("crc32_word_fold_core_tb: clean");
        end else begin
            $display("crc32_word_fold_core_tb: errors");
        end
        $finish;
    end

endmodule
